FILE: rtl/core/pscd_pkg.sv
// Shared types, character constants and the hex digit decoder of the percent decoder.
`timescale 1ns / 1ps
`default_nettype none

package pscd_pkg;

    // Characters the decoder emits or matches
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_PCT  = 7'b0000010,
        ST_ZERO = 7'b0000100,
        ST_BUF  = 7'b0001000,
        ST_CHAR = 7'b0010000,
        ST_CODE = 7'b0100000,
        ST_UTF  = 7'b1000000
    } state_t;

    // Control of the shared code accumulator
    typedef struct packed {
        logic clear;
        logic step;
    } code_ctl_t;

    // Result of a hex digit lookup
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_digit(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        case (c) inside
            [8'h30:8'h39]: h.val = 4'(c - 8'h30);
            [8'h61:8'h66]: h.val = 4'(c - 8'h57);
            [8'h41:8'h46]: h.val = 4'(c - 8'h37);
            default:       h.ok  = 1'b0;
        endcase
        return h;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/percent_sequence_decoder_utf8.sv
// Percent-sequence decoder to UTF-8: escape tracking, emit sequencer and output register.
// Output: a result is in the output register in the cycle after the sequencer emits it.
// Throughput: input stalls outside idle; a literal escape emits %, zeros, digits, pending byte;
// a decoded code folds digits, then emits UTF-8 bytes; one byte leaves per cycle unless stalled.
// Reset: rst_n clears escape state, sequencer and output valid at once; the buffer is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module percent_sequence_decoder_utf8 #(
    parameter int LOOKAHEAD_DEPTH = 10
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output      logic       in_stall,
    input  wire logic [7:0] in_char,
    input  wire logic       in_end,
    output      logic       out_valid,
    input  wire logic       out_stall,
    output      logic [7:0] out_char,
    output      logic       out_end
);

    localparam int IDX_W = $clog2(LOOKAHEAD_DEPTH);
    localparam int CNT_W = $clog2(LOOKAHEAD_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    pscd_pkg::state_t    state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                esc_reg;
    logic [3:0]          zrun_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [3:0]          run_z_reg;
    logic [CNT_W-1:0]    run_n_reg;
    logic [7:0]          char_reg;
    logic                char_pend_reg;
    logic                last_reg;
    logic                out_valid_reg;
    logic [7:0]          out_char_reg;
    logic                out_end_reg;

    logic                accept;
    logic                out_ok;
    logic                emit;
    logic [7:0]          emit_byte;
    pscd_pkg::hex_t      in_hex;
    pscd_pkg::hex_t      buf_hex;
    logic [7:0]          buf_rd;
    logic                buf_wr;
    pscd_pkg::code_ctl_t code_ctl;
    logic [1:0]          utf_len;
    logic [7:0]          utf_byte;
    pscd_pkg::state_t    after_run;

    // Accept plan
    logic                p_run;
    logic                p_char;
    logic                p_code;
    logic [7:0]          p_cv;
    logic [3:0]          p_rz;
    logic [CNT_W-1:0]    p_rn;
    logic                p_esc;
    logic [3:0]          p_z;
    logic [CNT_W-1:0]    p_n;

    assign in_stall  = (state_reg != pscd_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_ok    = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_end   = out_end_reg;
    assign in_hex    = pscd_pkg::hex_digit(in_char);
    assign buf_hex   = pscd_pkg::hex_digit(buf_rd);

    // Decide the escape update and the emit job for the incoming item
    always_comb
    begin
        logic [3:0]       zi;
        logic [CNT_W-1:0] ni;
        logic [SUM_W-1:0] hx;
        logic [SUM_W-1:0] need;

        zi     = zrun_reg + 4'd1;
        ni     = (cnt_reg < CNT_W'(LOOKAHEAD_DEPTH)) ? cnt_reg + CNT_W'(1) : cnt_reg;
        hx     = SUM_W'(zrun_reg[0]) + SUM_W'(ni);
        need   = SUM_W'({zrun_reg[3:1], 1'b0}) + SUM_W'(2);
        p_run  = 1'b0;
        p_char = 1'b0;
        p_code = 1'b0;
        p_cv   = in_char;
        p_rz   = 4'd0;
        p_rn   = '0;
        p_esc  = 1'b0;
        p_z    = 4'd0;
        p_n    = '0;
        buf_wr = 1'b0;

        if (!esc_reg)
        begin
            if (in_char == pscd_pkg::CH_PCT)
            begin
                // Trailing percent goes out alone
                p_run = in_end;
                p_esc = 1'b1;
            end
            else
            begin
                p_char = 1'b1;
            end
        end
        else if (!in_hex.ok)
        begin
            p_run = 1'b1;
            p_rz  = zrun_reg;
            p_rn  = cnt_reg;
            if ((zrun_reg == 4'd0) && (cnt_reg == '0))
            begin
                p_char = 1'b1;
            end
            else if (in_char != pscd_pkg::CH_PCT)
            begin
                p_char = 1'b1;
            end
            else if (in_end)
            begin
                p_char = 1'b1;
            end
            else
            begin
                // Stopping percent opens a fresh escape
                p_esc = 1'b1;
            end
        end
        else if ((cnt_reg == '0) && (in_char == pscd_pkg::CH_ZERO))
        begin
            if (zi[3] || in_end)
            begin
                p_run = 1'b1;
                p_rz  = zi;
            end
            else
            begin
                p_esc = 1'b1;
                p_z   = zi;
            end
        end
        else
        begin
            buf_wr = (cnt_reg < CNT_W'(LOOKAHEAD_DEPTH));
            p_rn   = ni;
            if (hx >= need)
            begin
                if (zrun_reg[3:2] != 2'd0)
                begin
                    p_char = 1'b1;
                    p_cv   = pscd_pkg::CH_QMARK;
                end
                else
                begin
                    p_code = 1'b1;
                end
            end
            else if (in_end)
            begin
                p_run = 1'b1;
                p_rz  = zrun_reg;
            end
            else
            begin
                p_esc = 1'b1;
                p_z   = zrun_reg;
                p_n   = ni;
            end
        end

        // Final byte closes any escape
        if (in_end)
        begin
            p_esc = 1'b0;
            p_z   = 4'd0;
            p_n   = '0;
        end
    end

    // Step the emit sequencer
    always_comb
    begin
        after_run     = char_pend_reg ? pscd_pkg::ST_CHAR : pscd_pkg::ST_IDLE;
        state_next    = state_reg;
        idx_next      = idx_reg;
        emit          = 1'b0;
        emit_byte     = char_reg;
        code_ctl      = '0;

        case (state_reg)
            pscd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    code_ctl.clear = 1'b1;
                    idx_next       = '0;
                    if (p_run)
                    begin
                        state_next = pscd_pkg::ST_PCT;
                    end
                    else if (p_char)
                    begin
                        state_next = pscd_pkg::ST_CHAR;
                    end
                    else if (p_code)
                    begin
                        state_next = pscd_pkg::ST_CODE;
                    end
                end
            end
            pscd_pkg::ST_PCT:
            begin
                if (out_ok)
                begin
                    emit      = 1'b1;
                    emit_byte = pscd_pkg::CH_PCT;
                    idx_next  = '0;
                    if (run_z_reg != 4'd0)
                    begin
                        state_next = pscd_pkg::ST_ZERO;
                    end
                    else if (run_n_reg != '0)
                    begin
                        state_next = pscd_pkg::ST_BUF;
                    end
                    else
                    begin
                        state_next = after_run;
                    end
                end
            end
            pscd_pkg::ST_ZERO:
            begin
                if (out_ok)
                begin
                    emit      = 1'b1;
                    emit_byte = pscd_pkg::CH_ZERO;
                    if (idx_reg == IDX_W'(run_z_reg) - IDX_W'(1))
                    begin
                        idx_next   = '0;
                        state_next = (run_n_reg != '0) ? pscd_pkg::ST_BUF : after_run;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            pscd_pkg::ST_BUF:
            begin
                if (out_ok)
                begin
                    emit      = 1'b1;
                    emit_byte = buf_rd;
                    if (CNT_W'(idx_reg) == run_n_reg - CNT_W'(1))
                    begin
                        idx_next   = '0;
                        state_next = after_run;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            pscd_pkg::ST_CHAR:
            begin
                if (out_ok)
                begin
                    emit       = 1'b1;
                    emit_byte  = char_reg;
                    state_next = pscd_pkg::ST_IDLE;
                end
            end
            pscd_pkg::ST_CODE:
            begin
                code_ctl.step = 1'b1;
                if (CNT_W'(idx_reg) == run_n_reg - CNT_W'(1))
                begin
                    idx_next   = '0;
                    state_next = pscd_pkg::ST_UTF;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            pscd_pkg::ST_UTF:
            begin
                if (out_ok)
                begin
                    emit      = 1'b1;
                    emit_byte = utf_byte;
                    if (idx_reg == IDX_W'(utf_len) - IDX_W'(1))
                    begin
                        idx_next   = '0;
                        state_next = pscd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = pscd_pkg::ST_IDLE;
                idx_next   = '0;
            end
        endcase
    end

    // Hold control and escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pscd_pkg::ST_IDLE;
            idx_reg       <= '0;
            esc_reg       <= 1'b0;
            zrun_reg      <= 4'd0;
            cnt_reg       <= '0;
            char_pend_reg <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (accept)
            begin
                esc_reg       <= p_esc;
                zrun_reg      <= p_z;
                cnt_reg       <= p_n;
                char_pend_reg <= p_char;
                last_reg      <= in_end;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Latch job payload and output byte
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            run_z_reg <= p_rz;
            run_n_reg <= p_rn;
            char_reg  <= p_cv;
        end
        if (emit)
        begin
            out_char_reg <= emit_byte;
            out_end_reg  <= last_reg && (state_next == pscd_pkg::ST_IDLE);
        end
    end

    // Read ahead at the next walk index so the entry is ready with the state
    pscd_lookahead #(
        .DEPTH (LOOKAHEAD_DEPTH)
    ) u_lookahead (
        .clk     (clk),
        .wr_en   (accept && buf_wr),
        .wr_idx  (cnt_reg[IDX_W-1:0]),
        .wr_data (in_char),
        .rd_idx  (idx_next),
        .rd_data (buf_rd)
    );

    pscd_code_unit u_code_unit (
        .clk      (clk),
        .ctl      (code_ctl),
        .digit    (buf_hex.val),
        .byte_sel (idx_reg[1:0]),
        .utf_len  (utf_len),
        .utf_byte (utf_byte)
    );

`ifndef ASSERT_OFF
    // Outside an escape no zeros or digits are held
    a_idle_escape_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !esc_reg |-> ((zrun_reg == 4'd0) && (cnt_reg == '0)))
        else $error("held run outside escape");

    // An escape never holds eight zeros or more than eight digits
    a_run_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (zrun_reg < 4'd8) && (cnt_reg <= CNT_W'(8)))
        else $error("escape run out of bounds");

    // A final byte leaves no escape open
    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_end) |=> !esc_reg)
        else $error("escape open after final byte");

    // Buffer walks always have at least one entry
    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == pscd_pkg::ST_BUF) || (state_reg == pscd_pkg::ST_CODE))
        |-> (run_n_reg != '0))
        else $error("empty buffer walk");

    // A new result never lands on one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/pscd_lookahead.sv
// Lookahead buffer holding the hex digits that follow the leading zeros of an escape.
`timescale 1ns / 1ps
`default_nettype none

module pscd_lookahead #(
    parameter int DEPTH = 10
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_idx,
    input  wire logic [7:0]                 wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_idx,
    output      logic [7:0]                 rd_data
);

    logic [7:0] buf_mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Store one digit per accepted item
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_mem[wr_idx] <= wr_data;
        end
    end

    // Register the entry the sequencer walks next; pass a digit stored at the same edge
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx == rd_idx))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= buf_mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pscd_code_unit.sv
// Shared shift-accumulate unit that folds hex digits into a code and splits it into UTF-8 bytes.
`timescale 1ns / 1ps
`default_nettype none

module pscd_code_unit (
    input  wire logic                clk,
    input  wire pscd_pkg::code_ctl_t ctl,
    input  wire logic [3:0]          digit,
    input  wire logic [1:0]          byte_sel,
    output      logic [1:0]          utf_len,
    output      logic [7:0]          utf_byte
);

    logic [15:0] code_reg;
    logic [15:0] code_next;

    // Shift in one digit per step, keep the low 16 bits
    always_comb
    begin
        code_next = code_reg;
        if (ctl.clear)
        begin
            code_next = 16'd0;
        end
        else if (ctl.step)
        begin
            code_next = {code_reg[11:0], digit};
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    // Pick the encoded length and the selected byte
    always_comb
    begin
        if (code_reg < 16'h0080)
        begin
            utf_len = 2'd1;
        end
        else if (code_reg < 16'h0800)
        begin
            utf_len = 2'd2;
        end
        else
        begin
            utf_len = 2'd3;
        end

        utf_byte = code_reg[7:0];
        case (byte_sel)
            2'd0:
            begin
                if (utf_len == 2'd1)
                begin
                    utf_byte = code_reg[7:0];
                end
                else if (utf_len == 2'd2)
                begin
                    utf_byte = {3'b110, code_reg[10:6]};
                end
                else
                begin
                    utf_byte = {4'b1110, code_reg[15:12]};
                end
            end
            2'd1:
            begin
                if (utf_len == 2'd2)
                begin
                    utf_byte = {2'b10, code_reg[5:0]};
                end
                else
                begin
                    utf_byte = {2'b10, code_reg[11:6]};
                end
            end
            2'd2:    utf_byte = {2'b10, code_reg[5:0]};
            default: utf_byte = code_reg[7:0];
        endcase
    end

endmodule

`default_nettype wire
